// ----- hdl/swmf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan window minimum filter package
// Shared widths, reset values, register map and transfer types.
// ----------------------------------------------------------------------------
package swmf_pkg;

  // range samples and results, in millimetres
  localparam int RANGE_BITS = 16;
  localparam int WSIZE_BITS = 5;

  // default largest half-width of the window
  localparam int DEF_MAX_HALF_WINDOW = 8;

  // register port
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam int REG_SEL_BIT   = 2;

  // register index, taken from the word address bit
  localparam logic REG_WINDOW_SIZE = 1'b0;
  localparam logic REG_NO_RETURN   = 1'b1;

  // register reset values
  localparam logic [WSIZE_BITS-1:0] RST_WINDOW_SIZE = 5'd5;
  localparam logic [RANGE_BITS-1:0] RST_NO_RETURN   = 16'd30000;

  typedef logic [RANGE_BITS-1:0] range_t;

  typedef struct packed {
    logic [RANGE_BITS-1:0] range_sample;
    logic                  last_in_scan;
  } sample_t;

  typedef struct packed {
    logic [RANGE_BITS-1:0] filtered_range;
    logic                  last_out;
  } result_t;

  // window control from the sequencer
  typedef struct packed {
    logic shift;    // take a new sample into the window
    logic restart;  // scan is done, clear the sample count
  } win_ctl_t;

endpackage

// ----- hdl/scan_window_min_filter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan window minimum filter
// Centred sliding-window minimum over the range samples of one laser scan.
//
// Samples enter on the sample channel (valid/stall), one per cycle, in scan
// order; the final sample of a scan carries last_in_scan. Results leave on
// the result channel through a two-entry output queue. The result for a
// sample is formed at the edge that transfers the sample h positions later
// (h = half-width) and is written into the output queue at that edge.
// Throughput is one sample per cycle while not stalled. A last sample releases up to h+1
// results: the first in its own transfer cycle, the rest one per cycle from
// the flush counter while the output queue has room, with the input stalled.
// The input also stalls while both output queue entries are held by a
// stalled receiver; no result is dropped or repeated.
// Registers (APB): window size at 0x0, no-return code at 0x4. Write them
// only while no scan is in flight.
// Reset restores register defaults and clears the sample count, flush state
// and output queue; window contents are not cleared and are never read
// before being written in the current scan.
// ----------------------------------------------------------------------------
module scan_window_min_filter_core #(
  parameter int MAX_HALF_WINDOW = swmf_pkg::DEF_MAX_HALF_WINDOW
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [swmf_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [swmf_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [swmf_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  swmf_pkg::sample_t                  sample_data,
  output logic                               result_valid,
  input  logic                               result_stall,
  output swmf_pkg::result_t                  result_data
);
  import swmf_pkg::*;

  localparam int HW_BITS   = $clog2(MAX_HALF_WINDOW + 1);
  localparam int DEPTH     = 2 * MAX_HALF_WINDOW + 1;
  localparam int SEEN_BITS = $clog2(DEPTH + 1);

  logic [HW_BITS-1:0]   half_width;
  range_t               no_return;
  logic [SEEN_BITS-1:0] seen_view;
  logic [SEEN_BITS-1:0] seen_m1;
  range_t               result_range;
  win_ctl_t             win_ctl;
  result_t              push_data;
  logic                 buf_full;

  logic                 accept;
  logic                 last;
  logic [HW_BITS-1:0]   top_pos;
  logic [HW_BITS-1:0]   emit_pos;
  logic                 emit;
  logic                 emit_last;
  logic                 restart;

  logic                 flushing;
  logic                 flushing_next;
  logic [HW_BITS-1:0]   flush_pos;
  logic [HW_BITS-1:0]   flush_pos_next;

  swmf_regs #(
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW)
  ) u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .half_width (half_width),
    .no_return  (no_return)
  );

  swmf_window #(
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW)
  ) u_window (
    .clk          (clk),
    .rst          (rst),
    .ctl          (win_ctl),
    .sample       (sample_data.range_sample),
    .pos          (emit_pos),
    .half_width   (half_width),
    .no_return    (no_return),
    .seen_view    (seen_view),
    .result_range (result_range)
  );

  swmf_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (emit),
    .push_data    (push_data),
    .full         (buf_full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  // hold the input while flushing or while the output queue is full
  assign sample_stall = flushing || buf_full;
  assign accept       = sample_valid && !sample_stall;
  assign last         = sample_data.last_in_scan;

  // oldest position to release on a last sample: h, clipped by scan length
  assign seen_m1 = seen_view - 1'b1;
  assign top_pos = (seen_m1 < SEEN_BITS'(half_width)) ? HW_BITS'(seen_m1) : half_width;

  // pick the window position and decide whether a result is produced
  always_comb begin
    flushing_next  = flushing;
    flush_pos_next = flush_pos;
    if (flushing) begin
      emit_pos  = flush_pos;
      emit      = !buf_full;
      emit_last = (flush_pos == '0);
      restart   = !buf_full && (flush_pos == '0);
      if (!buf_full) begin
        if (flush_pos == '0) begin
          flushing_next = 1'b0;
        end else begin
          flush_pos_next = flush_pos - 1'b1;
        end
      end
    end else if (last) begin
      emit_pos  = top_pos;
      emit      = accept;
      emit_last = (top_pos == '0);
      restart   = accept && (top_pos == '0);
      if (accept && (top_pos != '0)) begin
        flushing_next  = 1'b1;
        flush_pos_next = top_pos - 1'b1;
      end
    end else begin
      emit_pos  = half_width;
      emit      = accept && (seen_view > SEEN_BITS'(half_width));
      emit_last = 1'b0;
      restart   = 1'b0;
    end
  end

  assign win_ctl.shift   = accept;
  assign win_ctl.restart = restart;

  assign push_data.filtered_range = result_range;
  assign push_data.last_out       = emit_last;

  // flush sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      flushing  <= 1'b0;
      flush_pos <= '0;
    end else begin
      flushing  <= flushing_next;
      flush_pos <= flush_pos_next;
    end
  end

  // never push into a full queue
  assert property (@(posedge clk) disable iff (rst) emit |-> !buf_full)
    else $error("result pushed into full output queue");

  // a flush ends only after releasing the scan's final result
  assert property (@(posedge clk) disable iff (rst)
    ($fell(flushing) && !$past(rst)) |-> $past(emit && emit_last))
    else $error("flush ended without final result");

  // a last sample with pending results starts the flush one position lower
  assert property (@(posedge clk) disable iff (rst)
    (accept && last && (top_pos != '0)) |=>
      (flushing && (flush_pos == $past(top_pos) - 1'b1)))
    else $error("flush did not start at the expected position");

  // each flush step moves one position toward the newest sample
  assert property (@(posedge clk) disable iff (rst)
    (flushing && emit && (flush_pos != '0)) |=>
      (flushing && (flush_pos == $past(flush_pos) - 1'b1)))
    else $error("flush position skipped or held");

endmodule

// ----- hdl/swmf_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan window minimum filter configuration registers
// APB register file for window size and no-return code; derives the
// saturated half-width of the window.
// ----------------------------------------------------------------------------
module swmf_regs #(
  parameter int   MAX_HALF_WINDOW = swmf_pkg::DEF_MAX_HALF_WINDOW,
  localparam int  HW_BITS         = $clog2(MAX_HALF_WINDOW + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [swmf_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [swmf_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [swmf_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready,
  output logic [HW_BITS-1:0]                 half_width,
  output swmf_pkg::range_t                   no_return
);
  import swmf_pkg::*;

  logic [WSIZE_BITS-1:0] window_size;
  logic [WSIZE_BITS-1:0] size_eff;
  logic [WSIZE_BITS-1:0] size_m1;
  logic [WSIZE_BITS-1:0] half_raw;
  logic                  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= RST_WINDOW_SIZE;
      no_return   <= RST_NO_RETURN;
    end else if (wr_en) begin
      case (paddr[REG_SEL_BIT])
        REG_WINDOW_SIZE: window_size <= pwdata[WSIZE_BITS-1:0];
        REG_NO_RETURN:   no_return   <= pwdata[RANGE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[REG_SEL_BIT])
      REG_WINDOW_SIZE: prdata = APB_DATA_BITS'(window_size);
      REG_NO_RETURN:   prdata = APB_DATA_BITS'(no_return);
      default:         prdata = '0;
    endcase
  end

  // half-width: size zero counts as one, saturate at MAX_HALF_WINDOW
  always_comb begin
    size_eff = (window_size == '0) ? WSIZE_BITS'(1) : window_size;
    size_m1  = size_eff - 1'b1;
    half_raw = size_m1 >> 1;
    if (int'(half_raw) > MAX_HALF_WINDOW) begin
      half_width = HW_BITS'(MAX_HALF_WINDOW);
    end else begin
      half_width = HW_BITS'(half_raw);
    end
  end

endmodule

// ----- hdl/swmf_window.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan window minimum filter sample window
// Shift line of recent samples with a running prefix minimum per tap, a
// saturating sample count, and the result select for one window position.
// ----------------------------------------------------------------------------
module swmf_window #(
  parameter int  MAX_HALF_WINDOW = swmf_pkg::DEF_MAX_HALF_WINDOW,
  localparam int HW_BITS         = $clog2(MAX_HALF_WINDOW + 1),
  localparam int DEPTH           = 2 * MAX_HALF_WINDOW + 1,
  localparam int SEEN_BITS       = $clog2(DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  swmf_pkg::win_ctl_t      ctl,
  input  swmf_pkg::range_t        sample,
  input  logic [HW_BITS-1:0]      pos,
  input  logic [HW_BITS-1:0]      half_width,
  input  swmf_pkg::range_t        no_return,
  output logic [SEEN_BITS-1:0]    seen_view,
  output swmf_pkg::range_t        result_range
);
  import swmf_pkg::*;

  localparam int IDX_BITS = $clog2(DEPTH);

  range_t win       [DEPTH];
  range_t pmin      [DEPTH];
  range_t win_next  [DEPTH];
  range_t pmin_next [DEPTH];

  logic [SEEN_BITS-1:0] seen;
  logic [SEEN_BITS-1:0] seen_inc;
  logic [SEEN_BITS-1:0] seen_m1;
  logic [IDX_BITS-1:0]  pos_idx;
  logic [IDX_BITS-1:0]  reach_idx;
  logic [IDX_BITS-1:0]  last_idx;
  logic [IDX_BITS-1:0]  hi_idx;
  range_t               centre;
  range_t               prefix;

  // shift in the new sample; each tap keeps the minimum of itself and newer
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      if (!ctl.shift) begin
        win_next[k]  = win[k];
        pmin_next[k] = pmin[k];
      end else if (k == 0) begin
        win_next[k]  = sample;
        pmin_next[k] = sample;
      end else begin
        win_next[k]  = win[k-1];
        pmin_next[k] = (sample < pmin[k-1]) ? sample : pmin[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    win  <= win_next;
    pmin <= pmin_next;
  end

  // samples of the current scan, saturating at the window depth
  assign seen_inc  = (seen == SEEN_BITS'(DEPTH)) ? seen : seen + 1'b1;
  assign seen_view = ctl.shift ? seen_inc : seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else begin
      seen <= ctl.restart ? '0 : seen_view;
    end
  end

  // window reaches h taps older than pos, clipped at the scan start
  always_comb begin
    seen_m1   = seen_view - 1'b1;
    pos_idx   = IDX_BITS'(pos);
    reach_idx = pos_idx + IDX_BITS'(half_width);
    last_idx  = IDX_BITS'(seen_m1);
    hi_idx    = (reach_idx < last_idx) ? reach_idx : last_idx;
    centre    = win_next[pos_idx];
    prefix    = pmin_next[hi_idx];
    if (centre == no_return) begin
      result_range = no_return;
    end else begin
      result_range = (prefix < no_return) ? prefix : no_return;
    end
  end

endmodule

// ----- hdl/swmf_out_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan window minimum filter output buffer
// Two-entry result queue that decouples the receiver's stall from the
// sample input.
// ----------------------------------------------------------------------------
module swmf_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  swmf_pkg::result_t push_data,
  output logic              full,
  output logic              result_valid,
  input  logic              result_stall,
  output swmf_pkg::result_t result_data
);
  import swmf_pkg::*;

  localparam logic [1:0] BUF_DEPTH = 2'd2;

  result_t    mem [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       pop;

  assign pop          = result_valid && !result_stall;
  assign full         = (count == BUF_DEPTH);
  assign result_valid = (count != '0);
  assign result_data  = mem[rd_ptr];

  // store result payload
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sim/tb_scan_window_min_filter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan window minimum filter testbench
// Drives range scans into the core and compares every filtered result with a
// predicted windowed minimum. Both channels idle and stall at random. Each
// phase uses a new window size and no-return code, written over APB while the
// core is idle between scans.
// ----------------------------------------------------------------------------

// Predicts filtered ranges from accepted samples and checks them in order.
class scan_min_scoreboard;
  localparam int MaxHalf  = swmf_pkg::DEF_MAX_HALF_WINDOW;
  localparam int WinDepth = 2 * MaxHalf + 1;

  swmf_pkg::range_t          window_q [WinDepth];
  int unsigned               seen;
  logic [swmf_pkg::WSIZE_BITS-1:0] wsize;
  swmf_pkg::range_t          no_ret;
  swmf_pkg::result_t         expected_q [$];
  int unsigned               errors;

  function new();
    wsize  = swmf_pkg::RST_WINDOW_SIZE;
    no_ret = swmf_pkg::RST_NO_RETURN;
    seen   = 0;
    errors = 0;
    foreach (window_q[k]) window_q[k] = '0;
  endfunction

  // Half-width, with size zero taken as one and saturation at the maximum.
  function int unsigned half_width();
    int unsigned ws;
    int unsigned h;
    ws = wsize;
    if (ws == 0) ws = 1;
    h = (ws - 1) / 2;
    if (h > MaxHalf) h = MaxHalf;
    return h;
  endfunction

  // Minimum around window position pos, clipped at both ends of the scan.
  function swmf_pkg::range_t window_min(int unsigned pos, int unsigned h);
    int unsigned      hi;
    swmf_pkg::range_t m;
    hi = pos + h;
    if (hi > seen - 1) hi = seen - 1;
    if (hi > WinDepth - 1) hi = WinDepth - 1;
    if (window_q[pos] == no_ret) return no_ret;
    m = no_ret;
    for (int k = 0; k <= int'(hi); k++) begin
      if (window_q[k] < m) m = window_q[k];
    end
    return m;
  endfunction

  // Shift in an accepted sample and queue the results it releases.
  function void note_sample(swmf_pkg::sample_t s);
    int unsigned       h;
    int unsigned       top;
    swmf_pkg::result_t r;
    h = half_width();
    for (int k = WinDepth - 1; k > 0; k--) window_q[k] = window_q[k-1];
    window_q[0] = s.range_sample;
    if (seen < WinDepth) seen++;
    if (!s.last_in_scan) begin
      if (seen > h) begin
        r.filtered_range = window_min(h, h);
        r.last_out       = 1'b0;
        expected_q = {expected_q, r};
      end
    end else begin
      // flush every pending sample, oldest first
      top = (h > seen - 1) ? seen - 1 : h;
      for (int p = int'(top); p >= 0; p--) begin
        r.filtered_range = window_min(p, h);
        r.last_out       = (p == 0);
        expected_q = {expected_q, r};
      end
      seen = 0;
    end
  endfunction

  // Compare one accepted result with the oldest prediction.
  function void check_result(swmf_pkg::result_t got);
    swmf_pkg::result_t exp_r;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result: range %0d last %0b",
               $time, got.filtered_range, got.last_out);
      return;
    end
    exp_r = expected_q.pop_front();
    if (got.filtered_range !== exp_r.filtered_range) begin
      errors++;
      $display("%0t: filtered_range mismatch: expected %0d, actual %0d",
               $time, exp_r.filtered_range, got.filtered_range);
    end
    if (got.last_out !== exp_r.last_out) begin
      errors++;
      $display("%0t: last_out mismatch: expected %0b, actual %0b",
               $time, exp_r.last_out, got.last_out);
    end
  endfunction
endclass

module tb_scan_window_min_filter_core;
  import swmf_pkg::*;

  localparam logic [APB_ADDR_BITS-1:0] ADDR_WINDOW_SIZE = {REG_WINDOW_SIZE, 2'b00};
  localparam logic [APB_ADDR_BITS-1:0] ADDR_NO_RETURN   = {REG_NO_RETURN, 2'b00};
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 38;
  localparam int DRAIN_CYCLES    = 20;
  localparam int LONG_HOLD       = 80;

  logic                     clk;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;
  logic                     sample_valid;
  logic                     sample_stall;
  sample_t                  sample_data;
  logic                     result_valid;
  logic                     result_stall;
  result_t                  result_data;

  scan_min_scoreboard sb;
  bit tx_no_idle;
  bit rx_no_idle;
  bit hold_req;

  scan_window_min_filter_core dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_data  (sample_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("FAIL scan_window_min_filter_core");
    $finish;
  end

  // APB write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [APB_ADDR_BITS-1:0] addr,
                           input logic [APB_DATA_BITS-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one sample after a random gap and hold it until transfer.
  task automatic send_sample(input sample_t s);
    int unsigned gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      @(negedge clk);
      sample_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    sample_valid <= 1'b1;
    sample_data  <= s;
    do @(posedge clk); while (sample_stall);
    sb.note_sample(s);
  endtask

  // Send one scan; the final sample carries last_in_scan.
  task automatic send_scan(input range_t vals [$]);
    sample_t s;
    foreach (vals[i]) begin
      s.range_sample = vals[i];
      s.last_in_scan = (i == vals.size() - 1);
      send_sample(s);
    end
  endtask

  // Drop valid and wait until every predicted result has arrived.
  task automatic wait_idle();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Range draw biased toward the no-return code and the field extremes.
  function automatic range_t draw_range();
    int unsigned pick;
    range_t      nr;
    nr   = sb.no_ret;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return nr;
      1: return (nr == 16'hFFFF) ? nr : range_t'($urandom_range(int'(nr) + 1, 65535));
      2: return '0;
      3: return 16'hFFFF;
      4, 5, 6: return range_t'($urandom_range(0, int'(nr)));
      default: return range_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly short scans, some past the window depth.
  function automatic int unsigned draw_scan_len(bit long_scans);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (long_scans || pick == 9) return $urandom_range(25, 40);
    if (pick >= 7) return $urandom_range(13, 24);
    return $urandom_range(1, 12);
  endfunction

  // Result receiver: random stall before each transfer, one long hold-off.
  initial begin
    int unsigned w;
    result_stall = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        @(negedge clk);
        result_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else begin
        w = rx_no_idle ? 0 : $urandom_range(0, 5);
        if (w > 0) begin
          @(negedge clk);
          result_stall <= 1'b1;
          repeat (w - 1) @(negedge clk);
        end
      end
      @(negedge clk);
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
      sb.check_result(result_data);
    end
  end

  // Reset, directed scans, then randomized phases.
  initial begin
    logic [WSIZE_BITS-1:0] ws_tab [NUM_PHASES];
    range_t                nr_tab [NUM_PHASES];
    range_t                vals [$];
    int unsigned           sent;
    int unsigned           len;

    sb           = new();
    tx_no_idle   = 1'b0;
    rx_no_idle   = 1'b0;
    hold_req     = 1'b0;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    sample_valid = 1'b0;
    sample_data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: default registers, half-width two
    send_scan('{16'd1234});                              // single-sample scan
    send_scan('{16'd30000, 16'hFFFF});                   // short scan, no returns
    send_scan('{16'd0, 16'hFFFF, 16'd30000, 16'd30001,
                16'd29999, 16'd7, 16'hFFFF, 16'd100});   // extremes around the code
    send_scan('{16'd500, 16'd400, 16'd300, 16'd200, 16'd100,
                16'd200, 16'd300, 16'd400, 16'd500, 16'd30000});
    send_scan('{16'hFFFF, 16'hFFFF, 16'hFFFF});          // nothing valid at all

    // zero size, unit size, saturated size, full-scale codes, then random
    ws_tab = '{5'd0, 5'd1, 5'd31, 5'd17, 5'd2, 5'd16, 5'd3, 5'd0};
    nr_tab = '{16'hFFFF, 16'd0, 16'd30000, 16'hFFFF, 16'd1000,
               16'd30000, 16'd12345, 16'd0};
    ws_tab[NUM_PHASES-1] = WSIZE_BITS'($urandom_range(0, 31));
    nr_tab[NUM_PHASES-1] = range_t'($urandom_range(0, 65535));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      write_reg(ADDR_WINDOW_SIZE, APB_DATA_BITS'(ws_tab[ph]));
      sb.wsize = ws_tab[ph];
      write_reg(ADDR_NO_RETURN, APB_DATA_BITS'(nr_tab[ph]));
      sb.no_ret = nr_tab[ph];

      tx_no_idle = (ph == 3);
      rx_no_idle = (ph == 3) || (ph == 5);
      if (ph == 2) hold_req = 1'b1;

      // trim the final scan so each phase sends a fixed sample count
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        len = draw_scan_len(ph == 2);
        if (len > ITEMS_PER_PHASE - sent) len = ITEMS_PER_PHASE - sent;
        vals.delete();
        repeat (len) vals = {vals, draw_range()};
        send_scan(vals);
        sent += len;
      end
    end

    wait_idle();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS scan_window_min_filter_core");
    end else begin
      $display("FAIL scan_window_min_filter_core");
    end
    $finish;
  end

endmodule
